@@ sv/lfq_pkg.sv @@
package lfq_pkg;

  // item codes
  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_READ = 1'b1;

  // line terminators
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  // classified item, front to back
  typedef struct packed {
    logic       is_read;
    logic       is_term;
    logic [7:0] data_byte;
  } cmd_t;

  typedef struct packed {
    logic [7:0] line_byte;
    logic       last_of_line;
    logic       queue_empty;
  } result_t;

endpackage

@@ sv/lfq_item_if.sv @@
interface lfq_item_if ();
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] data_byte;

  modport source (output valid, output mode, output data_byte, input ready);
  modport sink (input valid, input mode, input data_byte, output ready);
endinterface

@@ sv/lfq_result_if.sv @@
interface lfq_result_if ();
  logic       valid;
  logic       ready;
  logic [7:0] line_byte;
  logic       last_of_line;
  logic       queue_empty;

  modport source (output valid, output line_byte, output last_of_line, output queue_empty,
                  input ready);
  modport sink (input valid, input line_byte, input last_of_line, input queue_empty,
                output ready);
endinterface

@@ sv/lfq_front.sv @@
module lfq_front import lfq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  lfq_item_if.sink   item,
  output logic       cmd_valid,
  output cmd_t       cmd,
  input  logic       cmd_ready
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  cmd_t       incoming;
  logic       take;
  logic       give;

  always_comb begin
    incoming.is_read   = (item.mode == MODE_READ);
    incoming.is_term   = (item.data_byte == CHAR_CR) || (item.data_byte == CHAR_LF);
    incoming.data_byte = item.data_byte;
  end

  assign item.ready = (fill != 2'd2);
  assign take       = item.valid && item.ready;
  assign cmd_valid  = (fill != 2'd0);
  assign cmd        = slots[rd_ptr];
  assign give       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (take) begin
      slots[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      wr_ptr <= wr_ptr ^ take;
      rd_ptr <= rd_ptr ^ give;
      fill   <= fill + {1'b0, take} - {1'b0, give};
    end
  end

endmodule

@@ sv/lfq_back.sv @@
module lfq_back import lfq_pkg::*; #(
  parameter int LINE_BYTES  = 256,
  parameter int QUEUE_LINES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  input  cmd_t        cmd,
  output logic        cmd_ready,
  lfq_result_if.source result
);

  // one spare slot: the line being assembled always has a free slot
  localparam int SLOTS     = QUEUE_LINES + 1;
  localparam int SLOTW     = $clog2(SLOTS);
  localparam int OFFW      = $clog2(LINE_BYTES);
  localparam int SUMW      = SLOTW + 1;
  localparam int MEM_DEPTH = SLOTS << OFFW;

  localparam logic [OFFW-1:0]  LEN_LIMIT  = OFFW'(LINE_BYTES - 1);
  localparam logic [SLOTW-1:0] QUEUE_CAP  = SLOTW'(QUEUE_LINES);
  localparam logic [SLOTW-1:0] SLOT_LAST  = SLOTW'(SLOTS - 1);
  localparam logic [SUMW-1:0]  SLOTS_SUM  = SUMW'(SLOTS);

  logic [7:0]      line_mem [MEM_DEPTH];
  logic [OFFW-1:0] len_mem  [SLOTS];

  logic [SLOTW-1:0] head_slot, head_slot_next;
  logic [SLOTW-1:0] queued_count, queued_count_next;
  logic [OFFW-1:0]  read_offset, read_offset_next;
  logic [OFFW-1:0]  assembly_length, assembly_length_next;

  logic [7:0]      mem_q;
  logic [OFFW-1:0] len_q;
  logic            b_valid;
  logic            b_last;
  logic            b_empty;

  result_t    rb_mem [2];
  logic       rb_wr;
  logic       rb_rd;
  logic [1:0] rb_fill;

  logic [SUMW-1:0]  tail_sum;
  logic [SLOTW-1:0] tail_slot;
  logic [SLOTW-1:0] head_inc;
  logic             rd_last;
  logic             pop;
  logic             issue_ok;
  logic             go;
  logic             do_push;
  logic             do_read;
  logic             have_line;
  logic             store_byte;
  logic             commit;
  logic             take_line;
  logic             line_done;

  always_comb begin
    tail_sum  = {1'b0, head_slot} + {1'b0, queued_count};
    tail_slot = (tail_sum >= SLOTS_SUM) ? SLOTW'(tail_sum - SLOTS_SUM)
                                         : tail_sum[SLOTW-1:0];
    head_inc  = (head_slot == SLOT_LAST) ? '0 : head_slot + SLOTW'(1);
    rd_last   = ({1'b0, read_offset} + (OFFW+1)'(1)) >= {1'b0, len_q};

    // room for an in-flight read: result buffer plus memory stage stay within two
    pop       = result.valid && result.ready;
    issue_ok  = ({1'b0, rb_fill} + {2'b0, b_valid}) < (3'd2 + {2'b0, pop});
    cmd_ready = !cmd.is_read || issue_ok;
    go        = cmd_valid && cmd_ready;
    do_push   = go && !cmd.is_read;
    do_read   = go && cmd.is_read;

    have_line  = (queued_count != '0);
    store_byte = do_push && !cmd.is_term && (assembly_length < LEN_LIMIT);
    commit     = do_push && cmd.is_term && (assembly_length != '0) &&
                 (queued_count < QUEUE_CAP);
    take_line  = do_read && have_line;
    line_done  = take_line && rd_last;

    assembly_length_next = assembly_length;
    if (do_push) begin
      if (cmd.is_term) begin
        assembly_length_next = '0;
      end else if (assembly_length < LEN_LIMIT) begin
        assembly_length_next = assembly_length + OFFW'(1);
      end else begin
        assembly_length_next = '0;
      end
    end

    queued_count_next = queued_count;
    if (commit) begin
      queued_count_next = queued_count + SLOTW'(1);
    end else if (line_done) begin
      queued_count_next = queued_count - SLOTW'(1);
    end

    head_slot_next = line_done ? head_inc : head_slot;

    read_offset_next = read_offset;
    if (take_line) begin
      read_offset_next = rd_last ? '0 : read_offset + OFFW'(1);
    end
  end

  // line store: bytes go straight into the tail slot
  always_ff @(posedge clk) begin
    if (store_byte) begin
      line_mem[{tail_slot, assembly_length}] <= cmd.data_byte;
    end
    if (take_line) begin
      mem_q <= line_mem[{head_slot, read_offset}];
    end
  end

  // lengths: len_q always tracks the head slot, write-first on a commit into it
  always_ff @(posedge clk) begin
    if (commit) begin
      len_mem[tail_slot] <= assembly_length;
    end
    if (commit && (tail_slot == head_slot_next)) begin
      len_q <= assembly_length;
    end else begin
      len_q <= len_mem[head_slot_next];
    end
  end

  always_ff @(posedge clk) begin
    b_last  <= rd_last && have_line;
    b_empty <= !have_line;
    if (b_valid) begin
      rb_mem[rb_wr].line_byte    <= b_empty ? 8'd0 : mem_q;
      rb_mem[rb_wr].last_of_line <= b_last;
      rb_mem[rb_wr].queue_empty  <= b_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_slot       <= '0;
      queued_count    <= '0;
      read_offset     <= '0;
      assembly_length <= '0;
      b_valid         <= 1'b0;
      rb_wr           <= 1'b0;
      rb_rd           <= 1'b0;
      rb_fill         <= 2'd0;
    end else begin
      head_slot       <= head_slot_next;
      queued_count    <= queued_count_next;
      read_offset     <= read_offset_next;
      assembly_length <= assembly_length_next;
      b_valid         <= do_read;
      rb_wr           <= rb_wr ^ b_valid;
      rb_rd           <= rb_rd ^ pop;
      rb_fill         <= rb_fill + {1'b0, b_valid} - {1'b0, pop};
    end
  end

  assign result.valid        = (rb_fill != 2'd0);
  assign result.line_byte    = rb_mem[rb_rd].line_byte;
  assign result.last_of_line = rb_mem[rb_rd].last_of_line;
  assign result.queue_empty  = rb_mem[rb_rd].queue_empty;

endmodule

@@ sv/line_deframer_queue_unit.sv @@
// CR/LF line deframer with a queue of whole lines.
// item channel: mode = push carries one received byte in data_byte; mode = read
//   asks for the next byte of the oldest queued line. Pushes give no result.
// result channel: one transfer per read - line_byte, last_of_line (the line
//   then leaves the queue) and queue_empty (no complete line; line_byte is 0).
// Terminators are not stored, empty lines are dropped, a line over
// LINE_BYTES-1 bytes is discarded with its overflowing byte, and a line
// completed while QUEUE_LINES lines wait is dropped silently.
// Throughput: one item per cycle while the receiver takes results; the line
//   store is touched at most once per item (a push may write, a read may read).
// Read path: a read is registered in turn in the front queue, the line store
//   read stage and the result buffer before its result is presented.
// Reset (rst, synchronous): queue empty, assembly cleared. No clearing pass.
// Receiver stall: the two-entry result buffer fills, reads stop issuing,
//   then the front queue fills and item ready drops. Pushes keep flowing as
//   long as no read waits at the head of the front queue.
module line_deframer_queue_unit import lfq_pkg::*; #(
  parameter int LINE_BYTES  = 256,
  parameter int QUEUE_LINES = 8
) (
  input  logic         clk,
  input  logic         rst,
  lfq_item_if.sink     item,
  lfq_result_if.source result
);

  // classified items from front to back
  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  // front: accepts items, tags reads and terminators, short queue
  lfq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_ready (cmd_ready)
  );

  // back: line assembly, line store, read-out and result buffer
  lfq_back #(
    .LINE_BYTES  (LINE_BYTES),
    .QUEUE_LINES (QUEUE_LINES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_ready (cmd_ready),
    .result    (result)
  );

endmodule
